// ----- sv/sscd_pkg.sv -----
// Shared types, codes and segment tables for the seven-segment counter display block.
package sscd_pkg;

  localparam int MAX_DIGITS     = 8;
  localparam int DIGITS_DEFAULT = 8;
  localparam int STEP_W         = 3;
  localparam int ADDR_W         = 4;
  localparam int VAL_W          = 8;
  localparam int BCD_W          = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 4;
  localparam int IN_DATA_W      = 8;
  localparam int OUT_DATA_W     = 16;
  localparam int INIT_WRITES    = 5;

  localparam logic [2:0] FUNC_INCR  = 3'd0;
  localparam logic [2:0] FUNC_COUNT = 3'd1;
  localparam logic [2:0] FUNC_MSG   = 3'd2;
  localparam logic [2:0] FUNC_ZEROS = 3'd3;
  localparam logic [2:0] FUNC_INIT  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT = 2'd1;

  localparam logic [ADDR_W-1:0] REG_DECODE   = 4'h9;
  localparam logic [ADDR_W-1:0] REG_BRIGHT   = 4'hA;
  localparam logic [ADDR_W-1:0] REG_SCAN     = 4'hB;
  localparam logic [ADDR_W-1:0] REG_SHUTDOWN = 4'hC;
  localparam logic [ADDR_W-1:0] REG_TEST     = 4'hF;

  localparam logic [VAL_W-1:0] SEG_ZERO = 8'h7E;

  typedef enum logic [2:0] {
    CMD_INCR,
    CMD_COUNT,
    CMD_MSG,
    CMD_ZEROS,
    CMD_INIT
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } back_state_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [2:0] sel;
  } cmd_entry_t;

  localparam logic [VAL_W-1:0] HEX_SEG [16] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
    8'h7F, 8'h7B, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47
  };

  localparam logic [VAL_W-1:0] MSG_TAB [6][8] = '{
    '{8'h4F, 8'h05, 8'h05, 8'h1D, 8'h05, 8'h00, 8'h7E, 8'h00},
    '{8'h4E, 8'h7E, 8'h76, 8'h76, 8'h4F, 8'h4E, 8'h70, 8'hC0},
    '{8'h3D, 8'h30, 8'h5B, 8'h4E, 8'h7E, 8'h76, 8'h76, 8'h80},
    '{8'h7F, 8'h77, 8'h3D, 8'h00, 8'h5B, 8'h30, 8'h6D, 8'h4F},
    '{8'h7F, 8'h77, 8'h3D, 8'h00, 8'h67, 8'h7E, 8'h5B, 8'h00},
    '{8'h7F, 8'h77, 8'h3D, 8'h00, 8'h40, 8'h46, 8'h77, 8'h5E}
  };

endpackage

// ----- sv/sscd_front.sv -----
// Front end: accepts input items, decodes the function and pushes commands to the queue.
module sscd_front (
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sscd_pkg::IN_DATA_W-1:0]  in_tdata,   // [2:0] func, [5:3] status_code
  input  logic                            q_full,
  output logic                            q_push,
  output sscd_pkg::cmd_entry_t            q_entry
);

  logic [2:0] func;
  logic [2:0] status_code;
  logic       known;

  assign func        = in_tdata[2:0];
  assign status_code = in_tdata[5:3];
  assign in_tready   = !q_full;

  always_comb begin
    known       = 1'b1;
    q_entry.cmd = sscd_pkg::CMD_INCR;
    case (func)
      sscd_pkg::FUNC_INCR:  q_entry.cmd = sscd_pkg::CMD_INCR;
      sscd_pkg::FUNC_COUNT: q_entry.cmd = sscd_pkg::CMD_COUNT;
      sscd_pkg::FUNC_MSG:   q_entry.cmd = sscd_pkg::CMD_MSG;
      sscd_pkg::FUNC_ZEROS: q_entry.cmd = sscd_pkg::CMD_ZEROS;
      sscd_pkg::FUNC_INIT:  q_entry.cmd = sscd_pkg::CMD_INIT;
      default:              known = 1'b0;
    endcase
    if (status_code >= 3'd1 && status_code <= 3'd5) begin
      q_entry.sel = status_code;
    end else begin
      q_entry.sel = 3'd0;
    end
  end

  // Undefined functions are accepted and dropped here.
  assign q_push = in_tvalid && !q_full && known;

endmodule

// ----- sv/sscd_queue.sv -----
// Two-entry command queue between the front end and the back end.
module sscd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sscd_pkg::cmd_entry_t push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output sscd_pkg::cmd_entry_t head
);

  sscd_pkg::cmd_entry_t mem_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- sv/sscd_back.sv -----
// Back end: keeps the BCD counter and sequences the driver register writes.
module sscd_back #(
  parameter int DIGITS = sscd_pkg::DIGITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             head_valid,
  input  sscd_pkg::cmd_entry_t             head,
  output logic                             pop,
  input  logic [3:0]                       brightness,
  input  logic [2:0]                       scan_limit,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sscd_pkg::OUT_DATA_W-1:0]  out_tdata,  // [3:0] reg_address, [11:4] reg_value
  output logic                             out_tlast   // last_write
);

  localparam logic [sscd_pkg::STEP_W-1:0] LAST_DIGIT = sscd_pkg::STEP_W'(DIGITS - 1);
  localparam logic [sscd_pkg::STEP_W-1:0] LAST_INIT  =
    sscd_pkg::STEP_W'(sscd_pkg::INIT_WRITES - 1);

  sscd_pkg::back_state_t state_r, state_nxt;
  sscd_pkg::cmd_t        cmd_r;
  logic [2:0]            sel_r;
  logic [sscd_pkg::STEP_W-1:0] step_r;
  logic [sscd_pkg::BCD_W-1:0]  count_r [sscd_pkg::MAX_DIGITS];
  logic [sscd_pkg::BCD_W-1:0]  count_inc [sscd_pkg::MAX_DIGITS];
  logic                  out_valid_r, out_valid_nxt;
  logic [sscd_pkg::ADDR_W-1:0] addr_r;
  logic [sscd_pkg::VAL_W-1:0]  val_r;
  logic                  last_r;
  logic                  emit;
  logic                  is_last;
  logic [sscd_pkg::ADDR_W-1:0] wr_addr;
  logic [sscd_pkg::VAL_W-1:0]  wr_val;
  logic                  carry;

  always_comb begin
    carry = 1'b1;
    for (int d = 0; d < sscd_pkg::MAX_DIGITS; d++) begin
      count_inc[d] = count_r[d];
      if (d < DIGITS && carry) begin
        if (count_r[d] >= 4'd9) begin
          count_inc[d] = 4'd0;
        end else begin
          count_inc[d] = count_r[d] + 4'd1;
          carry        = 1'b0;
        end
      end
    end
  end

  assign is_last = (cmd_r == sscd_pkg::CMD_INIT) ? (step_r == LAST_INIT)
                                                 : (step_r == LAST_DIGIT);

  always_comb begin
    wr_addr = sscd_pkg::ADDR_W'(DIGITS) - {1'b0, step_r};
    wr_val  = sscd_pkg::SEG_ZERO;
    case (cmd_r)
      sscd_pkg::CMD_COUNT: begin
        wr_val = sscd_pkg::HEX_SEG[count_r[LAST_DIGIT - step_r]];
      end
      sscd_pkg::CMD_MSG: begin
        wr_val = sscd_pkg::MSG_TAB[sel_r][step_r];
      end
      sscd_pkg::CMD_ZEROS: begin
        wr_addr = {1'b0, step_r} + 4'd1;
      end
      sscd_pkg::CMD_INIT: begin
        case (step_r)
          3'd0: begin
            wr_addr = sscd_pkg::REG_TEST;
            wr_val  = 8'h00;
          end
          3'd1: begin
            wr_addr = sscd_pkg::REG_SHUTDOWN;
            wr_val  = 8'h01;
          end
          3'd2: begin
            wr_addr = sscd_pkg::REG_SCAN;
            wr_val  = {5'd0, scan_limit};
          end
          3'd3: begin
            wr_addr = sscd_pkg::REG_BRIGHT;
            wr_val  = {4'd0, brightness};
          end
          default: begin
            wr_addr = sscd_pkg::REG_DECODE;
            wr_val  = 8'h00;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sscd_pkg::ST_IDLE: begin
        if (head_valid && head.cmd != sscd_pkg::CMD_INCR) begin
          state_nxt = sscd_pkg::ST_RUN;
        end
      end
      sscd_pkg::ST_RUN: begin
        if (emit && is_last) begin
          state_nxt = sscd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sscd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    emit = 1'b0;
    case (state_r)
      sscd_pkg::ST_IDLE: pop  = head_valid;
      sscd_pkg::ST_RUN:  emit = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sscd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      cmd_r       <= sscd_pkg::CMD_INCR;
      for (int d = 0; d < sscd_pkg::MAX_DIGITS; d++) begin
        count_r[d] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        cmd_r  <= head.cmd;
        step_r <= '0;
        if (head.cmd == sscd_pkg::CMD_INCR) begin
          count_r <= count_inc;
        end
      end else if (emit) begin
        step_r <= step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sel_r <= head.sel;
    end
    if (emit) begin
      addr_r <= wr_addr;
      val_r  <= wr_val;
      last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, val_r, addr_r};
  assign out_tlast  = last_r;

endmodule

// ----- sv/seven_segment_counter_display.sv -----
// Top level of the seven-segment counter display command block.
//
// Channel   Direction  Payload
// in_       slave      tdata[2:0] func, tdata[5:3] status_code
// out_      master     tdata[3:0] reg_address, tdata[11:4] reg_value, tlast last_write
// cfg_      slave      cfg_index (0 brightness, 1 scan_limit), cfg_data
//
// A display command leaves the queue, then the sequencer issues one register write
// per cycle while the output is not stalled: DIGITS writes for show commands, five
// for initialize, none for increment. The back end's write sequencer sets that rate.
// Reset clears the counter to zero, brightness to 15 and scan limit to 7.
// A stalled output holds the sequencer; the two-entry queue keeps taking items until full.
module seven_segment_counter_display #(
  parameter int DIGITS = sscd_pkg::DIGITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sscd_pkg::IN_DATA_W-1:0]   in_tdata,   // [2:0] func, [5:3] status_code
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sscd_pkg::OUT_DATA_W-1:0]  out_tdata,  // [3:0] reg_address, [11:4] reg_value
  output logic                             out_tlast,  // last_write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sscd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sscd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                 q_full;
  logic                 q_push;
  sscd_pkg::cmd_entry_t q_entry;
  logic                 q_pop;
  logic                 q_head_valid;
  sscd_pkg::cmd_entry_t q_head;
  logic [3:0]           brightness_r;
  logic [2:0]           scan_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= 4'd15;
      scan_limit_r <= 3'd7;
    end else if (cfg_valid) begin
      if (cfg_index == sscd_pkg::CFG_BRIGHTNESS) begin
        brightness_r <= cfg_data;
      end else if (cfg_index == sscd_pkg::CFG_SCAN_LIMIT) begin
        scan_limit_r <= cfg_data[2:0];
      end
    end
  end

  sscd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  sscd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  sscd_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .brightness (brightness_r),
    .scan_limit (scan_limit_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the seven-segment counter display command block.
module tb #(
  parameter int DIGITS = sscd_pkg::DIGITS_DEFAULT
);
  timeunit 1ns;
  timeprecision 1ps;

  import sscd_pkg::*;

  localparam logic [2:0] FUNC_RSVD5 = 3'd5;
  localparam logic [2:0] FUNC_RSVD6 = 3'd6;
  localparam logic [2:0] FUNC_RSVD7 = 3'd7;

  localparam logic [2:0] STATUS_UNKNOWN    = 3'd0;
  localparam logic [2:0] STATUS_CONNECT    = 3'd1;
  localparam logic [2:0] STATUS_DISCONNECT = 3'd2;
  localparam logic [2:0] STATUS_SIZE       = 3'd3;
  localparam logic [2:0] STATUS_POSITION   = 3'd4;
  localparam logic [2:0] STATUS_TAG        = 3'd5;
  localparam logic [2:0] STATUS_SPARE6     = 3'd6;
  localparam logic [2:0] STATUS_SPARE7     = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 16;
  localparam int CARRY_SWEEP   = 12;

  localparam logic [VAL_W-1:0] DIGIT_SEGMENTS [16] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
    8'h7F, 8'h7B, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47
  };

  // Row 0 is the unknown-error text; byte 0 lands on the highest digit.
  localparam logic [VAL_W-1:0] STATUS_TEXT [6][8] = '{
    '{8'h4F, 8'h05, 8'h05, 8'h1D, 8'h05, 8'h00, 8'h7E, 8'h00},
    '{8'h4E, 8'h7E, 8'h76, 8'h76, 8'h4F, 8'h4E, 8'h70, 8'hC0},
    '{8'h3D, 8'h30, 8'h5B, 8'h4E, 8'h7E, 8'h76, 8'h76, 8'h80},
    '{8'h7F, 8'h77, 8'h3D, 8'h00, 8'h5B, 8'h30, 8'h6D, 8'h4F},
    '{8'h7F, 8'h77, 8'h3D, 8'h00, 8'h67, 8'h7E, 8'h5B, 8'h00},
    '{8'h7F, 8'h77, 8'h3D, 8'h00, 8'h40, 8'h46, 8'h77, 8'h5E}
  };

  typedef struct {
    logic [ADDR_W-1:0] address;
    logic [VAL_W-1:0]  value;
    logic              last;
  } reg_write_t;

  class display_write_scoreboard;
    int unsigned       ndig;
    logic [BCD_W-1:0]  count_digits [MAX_DIGITS];
    logic [3:0]        brightness;
    logic [2:0]        scan_limit;
    reg_write_t        pending_writes [$];
    int unsigned       mismatches;

    function new(int digits);
      ndig = (digits < 1) ? 1 : ((digits > MAX_DIGITS) ? MAX_DIGITS : digits);
      foreach (count_digits[i]) count_digits[i] = '0;
      brightness = 4'd15;
      scan_limit = 3'd7;
      mismatches = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == CFG_BRIGHTNESS) begin
        brightness = data[3:0];
      end else if (index == CFG_SCAN_LIMIT) begin
        scan_limit = data[2:0];
      end
    endfunction

    function void push_write(logic [ADDR_W-1:0] address, logic [VAL_W-1:0] value,
                             logic last);
      reg_write_t w;
      w.address = address;
      w.value   = value;
      w.last    = last;
      pending_writes.push_back(w);
    endfunction

    function void note_command(logic [2:0] func, logic [2:0] code);
      int sel;
      case (func)
        FUNC_INCR: begin
          for (int d = 0; d < ndig; d++) begin
            if (count_digits[d] >= 4'd9) begin
              count_digits[d] = '0;
            end else begin
              count_digits[d] = count_digits[d] + 4'd1;
              break;
            end
          end
        end
        FUNC_COUNT: begin
          for (int d = ndig; d >= 1; d--)
            push_write(ADDR_W'(d), DIGIT_SEGMENTS[count_digits[d-1]], d == 1);
        end
        FUNC_MSG: begin
          sel = (code >= STATUS_CONNECT && code <= STATUS_TAG) ? int'(code) : 0;
          for (int d = 0; d < ndig; d++)
            push_write(ADDR_W'(ndig - d), STATUS_TEXT[sel][d], d == ndig - 1);
        end
        FUNC_ZEROS: begin
          for (int d = 1; d <= ndig; d++)
            push_write(ADDR_W'(d), DIGIT_SEGMENTS[0], d == ndig);
        end
        FUNC_INIT: begin
          push_write(REG_TEST, 8'h00, 1'b0);
          push_write(REG_SHUTDOWN, 8'h01, 1'b0);
          push_write(REG_SCAN, {5'd0, scan_limit}, 1'b0);
          push_write(REG_BRIGHT, {4'd0, brightness}, 1'b0);
          push_write(REG_DECODE, 8'h00, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_write(logic [ADDR_W-1:0] address, logic [VAL_W-1:0] value,
                              logic last);
      reg_write_t w;
      if (pending_writes.size() == 0) begin
        mismatches++;
        $error("reg_address: expected no write, actual %0h", address);
        return;
      end
      w = pending_writes.pop_front();
      if (address !== w.address) begin
        mismatches++;
        $error("reg_address: expected %0h, actual %0h", w.address, address);
      end
      if (value !== w.value) begin
        mismatches++;
        $error("reg_value: expected %0h, actual %0h", w.value, value);
      end
      if (last !== w.last) begin
        mismatches++;
        $error("last_write: expected %0b, actual %0b", w.last, last);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  display_write_scoreboard tracker;

  seven_segment_counter_display #(.DIGITS(DIGITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        tracker.check_write(out_tdata[3:0], out_tdata[11:4], out_tlast);
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_command(input logic [2:0] func, input logic [2:0] code);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, code, func};
    do @(posedge clk); while (!in_tready);
    tracker.note_command(func, code);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_register(index, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Increments leave nothing to wait for, so a settle time follows the drain.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (tracker.pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int unsigned idle_pct, input int unsigned stall_pct);
    logic [2:0] func;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    send_command(FUNC_INIT, 3'($urandom_range(7)));
    for (int i = 1; i < PHASE_ITEMS; i++) begin
      if ($urandom_range(99) < 12)
        func = 3'($urandom_range(7, 5));
      else
        func = 3'($urandom_range(4));
      send_command(func, 3'($urandom_range(7)));
    end
  endtask

  initial begin
    tracker = new(DIGITS);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_command(FUNC_INIT, STATUS_UNKNOWN);
    send_command(FUNC_MSG, STATUS_UNKNOWN);
    send_command(FUNC_MSG, STATUS_CONNECT);
    send_command(FUNC_MSG, STATUS_DISCONNECT);
    send_command(FUNC_MSG, STATUS_SIZE);
    send_command(FUNC_MSG, STATUS_POSITION);
    send_command(FUNC_MSG, STATUS_TAG);
    send_command(FUNC_MSG, STATUS_SPARE6);
    send_command(FUNC_MSG, STATUS_SPARE7);
    send_command(FUNC_ZEROS, STATUS_SPARE7);
    send_command(FUNC_RSVD5, STATUS_TAG);
    send_command(FUNC_RSVD6, STATUS_CONNECT);
    send_command(FUNC_RSVD7, STATUS_SPARE7);
    for (int i = 0; i < 9; i++) send_command(FUNC_INCR, 3'($urandom_range(7)));
    send_command(FUNC_COUNT, STATUS_UNKNOWN);
    send_command(FUNC_INCR, STATUS_SPARE7);
    send_command(FUNC_COUNT, STATUS_SPARE7);

    wait_idle();
    write_register(CFG_BRIGHTNESS, 4'd0);
    write_register(CFG_SCAN_LIMIT, 4'd0);
    run_random(0, 0);

    wait_idle();
    write_register(CFG_BRIGHTNESS, 4'd15);
    write_register(CFG_SCAN_LIMIT, 4'd15);
    run_random(74, 0);

    wait_idle();
    write_register(CFG_BRIGHTNESS, 4'($urandom_range(15)));
    write_register(CFG_SCAN_LIMIT, 4'($urandom_range(15)));
    run_random(0, 74);

    wait_idle();
    write_register(CFG_SPARE2, 4'($urandom_range(15)));
    write_register(CFG_SPARE3, 4'($urandom_range(15)));
    write_register(CFG_BRIGHTNESS, 4'($urandom_range(15)));
    write_register(CFG_SCAN_LIMIT, 4'($urandom_range(7)));
    run_random(32, 32);

    // A closing run of increments carries into the tens digit before the last display.
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    for (int i = 0; i < CARRY_SWEEP; i++) send_command(FUNC_INCR, 3'($urandom_range(7)));
    send_command(FUNC_COUNT, 3'($urandom_range(7)));

    wait_idle();
    if (tracker.mismatches == 0 && tracker.pending_writes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- seven_segment_counter_display.f -----
sv/sscd_pkg.sv
sv/sscd_front.sv
sv/sscd_queue.sv
sv/sscd_back.sv
sv/seven_segment_counter_display.sv
tb/sv/tb.sv
